// File: hdl/pli_pkg.sv
// Shared types, constants and command structs of the piecewise linear interpolator.
package pli_pkg;

  localparam int MaxPointsDefault = 64;
  localparam int CountWidth = 7;

  localparam logic [1:0] StatusInside = 2'd0;
  localparam logic [1:0] StatusLow = 2'd1;
  localparam logic [1:0] StatusHigh = 2'd2;
  localparam logic [1:0] StatusBad = 2'd3;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic load_write;
    logic load_check;
    logic rd_first;
    logic rd_last;
    logic rd_seg;
    logic seg_test;
    logic seg_next;
    logic mul_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic below;
    logic above;
    logic seg_hit;
    logic seg_end;
    logic div_done;
  } sts_t;

endpackage

// File: hdl/piecewise_linear_interpolator_top.sv
// Top level of the piecewise linear interpolator.
// An evaluate item ends without the divider when the table is invalid, when the query
// clamps low or high, or when no segment holds it. When the query lies in a segment, the
// search over the breakpoint memory tests one segment per cycle, then a multiply and a
// 32-step restoring divider form the fraction.
// A result waits in the output register; the next item is taken once it is gone.
module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = pli_pkg::MaxPointsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pli_pkg::CountWidth-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  pli_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output pli_pkg::out_item_t out_item
);

  logic [pli_pkg::CountWidth-1:0] points_in_use;
  pli_pkg::cmd_t cmd;
  pli_pkg::sts_t sts;
  pli_pkg::out_item_t dp_item;
  logic clamp_sel;
  logic [1:0] clamp_status;
  logic signed [31:0] clamp_val;
  logic signed [31:0] y_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= pli_pkg::CountWidth'(2);
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  pli_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_mode(in_item.mode), .sts, .cmd,
    .out_valid, .out_ready, .clamp_sel, .clamp_status
  );

  pli_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk, .rst, .points_in_use, .in_item, .cmd, .sts, .out_item(dp_item),
    .y_rd(y_hold)
  );

  always_comb begin
    out_item = dp_item;
    if (clamp_sel) begin
      out_item.status = clamp_status;
      out_item.value = (clamp_status == pli_pkg::StatusBad ||
                        clamp_status == pli_pkg::StatusInside) ? 32'sd0 : clamp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_last) begin
      clamp_val <= y_hold;
    end
  end

endmodule

// File: hdl/pli_datapath.sv
// Datapath: breakpoint memories, segment search, multiplier and serial divider.
module pli_datapath #(
  parameter int MAX_POINTS = pli_pkg::MaxPointsDefault,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [pli_pkg::CountWidth-1:0] points_in_use,
  input  pli_pkg::in_item_t in_item,
  input  pli_pkg::cmd_t cmd,
  output pli_pkg::sts_t sts,
  output pli_pkg::out_item_t out_item,
  output logic [31:0] y_rd
);

  logic [31:0] x_mem [MAX_POINTS];
  logic [31:0] y_mem [MAX_POINTS];
  logic [31:0] x_rd;
  logic [AW-1:0] rd_addr;
  pli_pkg::in_item_t item;
  logic table_bad;
  logic [AW-1:0] seg;
  logic [AW-1:0] last_idx;
  logic [pli_pkg::CountWidth-1:0] n_clamp;
  logic signed [31:0] xa;
  logic signed [31:0] ya;
  logic have_a;
  logic [32:0] dq;
  logic [32:0] len;
  logic dy_neg;
  logic [32:0] mag;
  logic [63:0] prod;
  logic [64:0] rem;
  logic [31:0] quo;
  logic [5:0] dcnt;
  logic [1:0] phase;
  logic [31:0] value;
  logic [1:0] status;
  logic [33:0] diff;
  logic idx_ok;

  always_comb begin
    if (points_in_use < pli_pkg::CountWidth'(2)) begin
      n_clamp = pli_pkg::CountWidth'(2);
    end else if (32'(points_in_use) > 32'(MAX_POINTS)) begin
      n_clamp = pli_pkg::CountWidth'(MAX_POINTS);
    end else begin
      n_clamp = points_in_use;
    end
  end
  assign last_idx = AW'(n_clamp - pli_pkg::CountWidth'(1));
  assign idx_ok = 32'(item.point_index) < 32'(MAX_POINTS);

  always_comb begin
    rd_addr = seg;
    if (cmd.take) begin
      rd_addr = AW'(in_item.point_index - 6'd1);
    end else if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.rd_last) begin
      rd_addr = last_idx;
    end else if (cmd.seg_next) begin
      rd_addr = seg + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write && idx_ok) begin
      x_mem[AW'(item.point_index)] <= item.point_x;
      y_mem[AW'(item.point_index)] <= item.point_y;
    end
    x_rd <= x_mem[rd_addr];
    y_rd <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bad <= 1'b0;
    end else if (cmd.load_check && idx_ok) begin
      if (item.point_index == 6'd0) begin
        table_bad <= 1'b0;
      end else if ($signed(item.point_x) <= $signed(x_rd)) begin
        table_bad <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_item;
    end
  end

  assign sts.bad = table_bad;
  assign sts.below = $signed(item.query_x) < $signed(x_rd);
  assign sts.above = $signed(item.query_x) > $signed(x_rd);
  assign sts.seg_hit = have_a && ($signed(item.query_x) >= xa)
                       && ($signed(item.query_x) <= $signed(x_rd));
  assign sts.seg_end = (seg == last_idx);
  assign sts.div_done = (dcnt == 6'd0) && (phase == 2'd0);

  assign diff = {1'b0, rem[64:32]} - {1'b0, len};
  assign prod = 64'(mag[31:0]) * 64'(dq[31:0]);

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      seg <= '0;
      have_a <= 1'b0;
    end else if (cmd.seg_next) begin
      seg <= seg + AW'(1);
    end
    if (cmd.seg_test) begin
      xa <= x_rd;
      ya <= y_rd;
      have_a <= 1'b1;
    end
    if (cmd.rd_seg) begin
      len <= 33'($signed(x_rd)) - 33'($signed(xa));
      dq <= 33'($signed(item.query_x)) - 33'($signed(xa));
      mag <= ($signed(y_rd) < ya) ? 33'($signed(ya)) - 33'($signed(y_rd))
                                  : 33'($signed(y_rd)) - 33'($signed(ya));
      dy_neg <= $signed(y_rd) < ya;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
      phase <= 2'd0;
    end else if (cmd.mul_start) begin
      rem <= {1'b0, prod} + 65'(len[32:1]);
      phase <= 2'd1;
    end else if (phase == 2'd1) begin
      rem <= {rem[63:0], 1'b0};
      quo <= '0;
      dcnt <= 6'd32;
      phase <= 2'd0;
    end else if (cmd.div_step && dcnt != 6'd0) begin
      if (!diff[33]) begin
        rem <= {diff[31:0], rem[31:0], 1'b0};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[63:0], 1'b0};
        quo <= {quo[30:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item <= '{value: value, status: status};
    end
  end

  always_comb begin
    value = '0;
    status = pli_pkg::StatusInside;
    if (table_bad) begin
      status = pli_pkg::StatusBad;
    end else if (cmd.rd_last) begin
      value = '0;
    end else if (len == 33'd0) begin
      value = ya;
    end else begin
      value = dy_neg ? ya - quo : ya + quo;
    end
  end

endmodule

// File: hdl/pli_ctrl.sv
// Controller state machine sequencing loads, clamps, segment search and division.
module pli_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_mode,
  input  pli_pkg::sts_t sts,
  output pli_pkg::cmd_t cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic clamp_sel,
  output logic [1:0] clamp_status
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_FIRST = 10'b0000000100,
    S_CHK0  = 10'b0000001000,
    S_CHKN  = 10'b0000010000,
    S_SEARCH = 10'b0000100000,
    S_SEG   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_DIV   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic busy_out;
  logic fin;
  logic [1:0] cst_next;
  logic csel_next;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    fin = 1'b0;
    csel_next = 1'b0;
    cst_next = pli_pkg::StatusInside;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid && in_ready;
        if (in_valid && in_ready) begin
          state_next = (in_mode == pli_pkg::ModeLoad) ? S_LOAD : S_FIRST;
        end
      end
      S_LOAD: begin
        cmd.load_check = 1'b1;
        cmd.load_write = 1'b1;
        state_next = S_IDLE;
      end
      S_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next = S_CHK0;
      end
      S_CHK0: begin
        cmd.rd_last = 1'b1;
        if (sts.bad) begin
          fin = 1'b1;
          cst_next = pli_pkg::StatusBad;
          state_next = S_OUT;
        end else if (sts.below) begin
          fin = 1'b1;
          csel_next = 1'b1;
          cst_next = pli_pkg::StatusLow;
          state_next = S_OUT;
        end else begin
          state_next = S_CHKN;
        end
      end
      S_CHKN: begin
        if (sts.above) begin
          cmd.rd_last = 1'b1;
          fin = 1'b1;
          csel_next = 1'b1;
          cst_next = pli_pkg::StatusHigh;
          state_next = S_OUT;
        end else begin
          cmd.rd_first = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.seg_test = 1'b1;
        cmd.seg_next = 1'b1;
        state_next = S_SEG;
      end
      S_SEG: begin
        if (sts.seg_hit) begin
          cmd.rd_seg = 1'b1;
          state_next = S_MUL;
        end else if (sts.seg_end) begin
          fin = 1'b1;
          csel_next = 1'b1;
          cst_next = pli_pkg::StatusInside;
          state_next = S_OUT;
        end else begin
          cmd.seg_test = 1'b1;
          cmd.seg_next = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          fin = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy_out = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      clamp_sel <= 1'b0;
      clamp_status <= pli_pkg::StatusInside;
    end else begin
      state <= state_next;
      if (busy_out) begin
        out_valid <= 1'b1;
        clamp_sel <= csel_next || (cst_next == pli_pkg::StatusBad);
        clamp_status <= cst_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: verif/pli_checker.sv
// Checker for the piecewise linear interpolator: tracks the table, predicts each result and compares.
module pli_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [pli_pkg::CountWidth-1:0] cfg_wdata,
  input  logic in_valid,
  input  logic in_ready,
  input  pli_pkg::in_item_t in_item,
  input  logic out_valid,
  input  logic out_ready,
  input  pli_pkg::out_item_t out_item,
  output int errors,
  output int pending
);

  logic signed [31:0] bp_x [64];
  logic signed [31:0] bp_y [64];
  logic table_bad;
  logic [pli_pkg::CountWidth-1:0] count_reg;
  pli_pkg::out_item_t expected_q[$];
  int fail_count;

  assign errors = fail_count;
  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic pli_pkg::out_item_t interpolate(input logic signed [31:0] q);
    int n;
    pli_pkg::out_item_t r;
    longint xa, xb, dy, y0;
    longint unsigned mag, dq, seg_len, quot;
    logic [64:0] prod;
    n = (count_reg < 2) ? 2 : (count_reg > 64) ? 64 : int'(count_reg);
    r.value = '0;
    r.status = pli_pkg::StatusInside;
    if (table_bad) begin
      r.status = pli_pkg::StatusBad;
    end else if (q < bp_x[0]) begin
      r.value = bp_y[0];
      r.status = pli_pkg::StatusLow;
    end else if (q > bp_x[n-1]) begin
      r.value = bp_y[n-1];
      r.status = pli_pkg::StatusHigh;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        xa = longint'(bp_x[i]);
        xb = longint'(bp_x[i+1]);
        if (longint'(q) >= xa && longint'(q) <= xb) begin
          y0 = longint'(bp_y[i]);
          dy = longint'(bp_y[i+1]) - y0;
          mag = (dy < 0) ? -dy : dy;
          dq = longint'(q) - xa;
          seg_len = xb - xa;
          if (seg_len == 0) begin
            r.value = bp_y[i];
          end else begin
            prod = 65'(mag) * 65'(dq) + 65'(seg_len >> 1);
            quot = 64'(prod / 65'(seg_len));
            r.value = 32'((dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot));
          end
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pli_pkg::out_item_t exp_item;
    if (rst) begin
      table_bad <= 1'b0;
      count_reg <= pli_pkg::CountWidth'(2);
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        count_reg <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result value=%h status=%0d",
                           out_item.value, out_item.status));
        end else begin
          exp_item = expected_q.pop_front();
          if (out_item.value !== exp_item.value)
            report($sformatf("value %h, expected %h", out_item.value, exp_item.value));
          if (out_item.status !== exp_item.status)
            report($sformatf("status %0d, expected %0d", out_item.status, exp_item.status));
        end
      end
      if (in_valid && in_ready) begin
        if (in_item.mode == pli_pkg::ModeEval) begin
          expected_q.insert(expected_q.size(), interpolate(in_item.query_x));
        end else begin
          if (in_item.point_index == 6'd0)
            table_bad <= 1'b0;
          else if (in_item.point_x <= bp_x[6'(in_item.point_index - 6'd1)])
            table_bad <= 1'b1;
          bp_x[in_item.point_index] <= in_item.point_x;
          bp_y[in_item.point_index] <= in_item.point_y;
        end
      end
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the piecewise linear interpolator: stimulus, idling and verdict.
module tb_top;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [pli_pkg::CountWidth-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  pli_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  pli_pkg::out_item_t out_item;
  int errors;
  int pending;

  logic signed [31:0] tx [64];
  int npts;
  bit burst;

  piecewise_linear_interpolator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  pli_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic pli_pkg::in_item_t rand_item();
    pli_pkg::in_item_t it;
    it.mode = 1'($urandom);
    it.point_index = 6'($urandom);
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.query_x = $urandom;
    return it;
  endfunction

  task automatic send(input pli_pkg::in_item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if (it.mode == pli_pkg::ModeLoad) tx[it.point_index] = it.point_x;
  endtask

  task automatic load_point(input int idx, input logic signed [31:0] px,
                            input logic signed [31:0] py);
    pli_pkg::in_item_t it;
    it = rand_item();
    it.mode = pli_pkg::ModeLoad;
    it.point_index = 6'(idx);
    it.point_x = px;
    it.point_y = py;
    send(it);
  endtask

  task automatic evaluate(input logic signed [31:0] q);
    pli_pkg::in_item_t it;
    it = rand_item();
    it.mode = pli_pkg::ModeEval;
    it.query_x = q;
    send(it);
  endtask

  task automatic set_count(input int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= pli_pkg::CountWidth'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    npts = (v < 2) ? 2 : (v > 64) ? 64 : v;
  endtask

  function automatic logic signed [31:0] pick_query();
    longint lo, hi, span;
    int r;
    lo = longint'(tx[0]);
    hi = longint'(tx[npts-1]);
    span = hi - lo;
    r = $urandom_range(0, 9);
    if (r == 0 || span < 0) return $urandom;
    if (r == 1) return 32'(lo - 1 - longint'($urandom_range(0, 1000)));
    if (r == 2) return 32'(hi + 1 + longint'($urandom_range(0, 1000)));
    if (r == 3) return tx[$urandom_range(0, npts - 1)];
    return 32'(lo + longint'({$urandom, $urandom} % ($unsigned(span) + 64'd1)));
  endfunction

  task automatic reload_table(input int k);
    longint step, base, bx;
    step = longint'($urandom_range(1, 32'h03FF_FFFF));
    if ($urandom_range(0, 2) == 0) step = longint'($urandom_range(1, 64));
    base = -64'sd2147483648 +
           longint'({$urandom, $urandom} % (64'd4294967296 - 64'(64 * step)));
    for (int i = 0; i < k; i++) begin
      bx = base + i * step + longint'($urandom_range(0, 32'(step / 2)));
      load_point(i, 32'(bx), $urandom);
    end
  endtask

  initial begin
    int r;
    int phase_count;
    int evals;
    int counts [8];
    pli_pkg::in_item_t it;
    counts = '{2, 127, 3, 0, 33, 1, 100, 17};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    burst = 1'b0;
    npts = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_count(64);
    burst = 1'b1;
    for (int i = 0; i < 64; i++)
      load_point(i, (i == 63) ? 32'sh7FFF_FFFF : 32'sh8000_0100 + i * 32'sh0200_0000,
                 i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    burst = 1'b0;
    evaluate(32'sh8000_0000);
    evaluate(32'sh7FFF_FFFF);
    evaluate(tx[0]);
    evaluate(tx[5] + 32'sh0100_0000);
    evaluate(tx[5] + 32'sh0100_0001);
    evaluate(tx[62] + 1);
    load_point(10, tx[9], 32'sh0001_0000);
    evaluate(32'sh0000_0000);
    load_point(0, tx[0], 32'sh0000_0000);
    evaluate(tx[9]);
    load_point(10, tx[9] + 32'sh0200_0000, 32'sh7FFF_FFFF);
    set_count(3);
    evaluate(32'sh7FFF_FFFF);
    evaluate(tx[1] + 32'sh0000_1234);
    for (int p = 0; p < 8; p++) begin
      set_count(counts[p]);
      phase_count = 0;
      while (phase_count < 250) begin
        r = $urandom_range(0, 99);
        burst = ($urandom_range(0, 3) == 0);
        if (r < 12) begin
          it = rand_item();
          it.mode = pli_pkg::ModeLoad;
          send(it);
          phase_count++;
        end else if (r < 20) begin
          it = rand_item();
          it.mode = pli_pkg::ModeEval;
          send(it);
          phase_count++;
        end else begin
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 12);
          reload_table(r);
          evals = $urandom_range(5, 25);
          for (int e = 0; e < evals; e++) evaluate(pick_query());
          phase_count += r + evals;
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

endmodule
